@@ hdl/clss_pkg.sv @@
// Shared constants and types for the combined LCG shuffle generator.
`timescale 1ns / 1ps

package clss_pkg;

    localparam int WORD_W          = 31;
    localparam int SEED_W          = 32;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [WORD_W-1:0] MOD1       = 31'd2147483563;
    localparam logic [WORD_W-1:0] MOD2       = 31'd2147483399;
    localparam logic [WORD_W-1:0] MOD1_LESS1 = 31'd2147483562;
    localparam logic [WORD_W-1:0] GEN2_INIT  = 31'd123456789;

    // fold = 2^31 - modulus, so 2^31 is congruent to fold
    typedef struct packed {
        logic [15:0]       mul;
        logic [7:0]        fold;
        logic [WORD_W-1:0] modulus;
    } lcg_coef_t;

    localparam lcg_coef_t GEN1_COEF = '{mul: 16'd40014, fold: 8'd85,  modulus: MOD1};
    localparam lcg_coef_t GEN2_COEF = '{mul: 16'd40692, fold: 8'd249, modulus: MOD2};

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] res;
    } modmul_out_t;

endpackage

@@ hdl/clss_seed_if.sv @@
// Input channel: one seed per transaction.
`timescale 1ns / 1ps

interface clss_seed_if;
    logic                                valid;
    logic                                ready;
    logic signed [clss_pkg::SEED_W-1:0]  seed_in;

    modport source (output valid, output seed_in, input ready);
    modport sink   (input valid, input seed_in, output ready);
endinterface

@@ hdl/clss_rand_if.sv @@
// Output channel: new seed and shuffled value per transaction.
`timescale 1ns / 1ps

interface clss_rand_if;
    logic                        valid;
    logic                        ready;
    logic [clss_pkg::WORD_W-1:0] seed_out;
    logic [clss_pkg::WORD_W-1:0] random_raw;

    modport source (output valid, output seed_out, output random_raw, input ready);
    modport sink   (input valid, input seed_out, input random_raw, output ready);
endinterface

@@ hdl/clss_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module clss_ram #(
    parameter int WIDTH = clss_pkg::WORD_W,
    parameter int DEPTH = clss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/clss_modmul.sv @@
// Three-stage constant modular multiply: a * mul mod (2^31 - fold).
`timescale 1ns / 1ps

module clss_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  clss_pkg::lcg_coef_t       coef,
    input  logic                      start,
    input  logic [31:0]               a,
    output clss_pkg::modmul_out_t     result
);

    logic [47:0] p_reg, p_next;
    logic [31:0] s_reg, s_next;
    logic [30:0] r_reg, r_next;
    logic        v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        p_next = 48'(a) * 48'(coef.mul);
        // high part times fold plus low part stays below twice the modulus
        s_next = 32'(p_reg[47:31]) * 32'(coef.fold) + 32'(p_reg[30:0]);
        if (s_reg >= {1'b0, coef.modulus})
        begin
            r_next = 31'(s_reg - {1'b0, coef.modulus});
        end
        else
        begin
            r_next = s_reg[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            p_reg  <= '0;
            s_reg  <= '0;
            r_reg  <= '0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            p_reg  <= p_next;
            s_reg  <= s_next;
            r_reg  <= r_next;
        end
    end

    assign result.done = v3_reg;
    assign result.res  = r_reg;

endmodule

@@ hdl/clss_index.sv @@
// Three-stage table index: shuffle value / divisor by reciprocal, with clamp.
`timescale 1ns / 1ps

module clss_index #(
    parameter int TABLE_DEPTH = clss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [clss_pkg::WORD_W-1:0]    shuf,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] idx
);

    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int QW          = $clog2(TABLE_DEPTH + 1);
    localparam int RECIP_SHIFT = 38;
    localparam int PW          = RECIP_SHIFT + QW;
    localparam longint unsigned DIVISOR =
        64'(clss_pkg::MOD1_LESS1) / TABLE_DEPTH + 64'd1;
    // floor reciprocal: estimate is the true quotient or one below
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
    localparam logic [QW-1:0] LAST_Q = QW'(TABLE_DEPTH - 1);
    localparam logic [QW-1:0] DEPTH_Q = QW'(TABLE_DEPTH);

    logic [PW-1:0] p_reg, p_next;
    logic [30:0]   so1_reg, so2_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [30:0]   qd_reg, qd_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          v1_reg, v2_reg, v3_reg;
    logic [30:0]   rem;
    logic [QW-1:0] q_fix;

    always_comb
    begin
        p_next  = PW'(shuf) * PW'(RECIP);
        q_next  = p_reg[RECIP_SHIFT +: QW];
        qd_next = 31'(q_next) * 31'(DIVISOR);
        rem     = so2_reg - qd_reg;
        q_fix   = q_reg + QW'(rem >= 31'(DIVISOR));
        if (q_fix >= DEPTH_Q)
        begin
            idx_next = LAST_Q[AW-1:0];
        end
        else
        begin
            idx_next = q_fix[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            p_reg   <= '0;
            so1_reg <= '0;
            so2_reg <= '0;
            q_reg   <= '0;
            qd_reg  <= '0;
            idx_reg <= '0;
        end
        else
        begin
            v1_reg  <= start;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            p_reg   <= p_next;
            so1_reg <= shuf;
            so2_reg <= so1_reg;
            q_reg   <= q_next;
            qd_reg  <= qd_next;
            idx_reg <= idx_next;
        end
    end

    assign done = v3_reg;
    assign idx  = idx_reg;

endmodule

@@ hdl/combined_lcg_shuffle_rng.sv @@
// Top level: combined LCG pair with Bays-Durham shuffle table in RAM.
`timescale 1ns / 1ps

// Channel   Dir   Payload                          Transaction
// seed_ch   in    seed_in (32b signed)             valid && ready
// rand_ch   out   seed_out (31b), random_raw (31b) valid && ready
//
// Positive seed: both modular multiply units and the index run, the RAM
// read is registered, then S_DIFF and S_DONE; new seeds wait for S_IDLE.
// Reseed: the first generator's warm-up chain runs TABLE_DEPTH+8 steps,
// each launched as the one before finishes, then the regular step.
// Reset: per-entry valid bits make unwritten table entries read as zero;
// no clearing pass. A finished result waits in the output register while
// the next seed is accepted; only the S_DONE write-back and load wait on it.

module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = clss_pkg::TABLE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    clss_seed_if.sink     seed_ch,
    clss_rand_if.source   rand_ch
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int JW = $clog2(TABLE_DEPTH + 8);
    localparam logic [JW-1:0] WARM_FIRST = JW'(TABLE_DEPTH + 7);
    localparam logic [JW-1:0] WARM_FILL  = JW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a seed
        S_WARM,   // reseed: chained first-generator steps, table fill
        S_STEP,   // reseed done: launch the regular step
        S_CALC,   // both generators and the index in flight
        S_DIFF,   // table entry back from RAM
        S_DONE    // write-back and result load
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    x_reg, x_next;        // first-generator state
    logic [31:0]    yop_reg, yop_next;    // second-generator operand after reseed
    logic [30:0]    gen2_reg, gen2_next;
    logic [30:0]    shuf_reg, shuf_next;
    logic [JW-1:0]  warm_reg, warm_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           rd_valid_reg, rd_valid_next;
    logic [31:0]    diff_reg, diff_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic           out_valid_reg, out_valid_next;
    logic [30:0]    seed_out_reg, seed_out_next;
    logic [30:0]    raw_out_reg, raw_out_next;

    logic [31:0]    seed_word;
    logic           reseed;
    logic [31:0]    mag;
    logic           in_accept;
    logic           out_free;
    logic [31:0]    final_sum;

    logic                  x_start, y_start;
    logic [31:0]           x_op, y_op;
    clss_pkg::modmul_out_t x_out, y_out;
    logic                  idx_done;
    logic [AW-1:0]         idx_res;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [30:0]    ram_wdata, ram_rdata, rd_data;

    assign seed_word = seed_ch.seed_in;
    assign reseed    = (seed_word == 32'd0) || seed_word[31];
    // magnitude of a non-positive seed, zero taken as one
    assign mag       = (seed_word == 32'd0) ? 32'd1 : (~seed_word + 32'd1);
    assign seed_ch.ready = (state_reg == S_IDLE);
    assign in_accept = seed_ch.valid && seed_ch.ready;
    assign out_free  = !out_valid_reg || rand_ch.ready;
    assign rd_data   = rd_valid_reg ? ram_rdata : '0;
    assign final_sum = diff_reg + {1'b0, clss_pkg::MOD1_LESS1};

    // unit launch and operand selection
    always_comb
    begin
        x_start = in_accept
               || (state_reg == S_STEP)
               || ((state_reg == S_WARM) && x_out.done && (warm_reg != '0));
        y_start = (in_accept && !reseed) || (state_reg == S_STEP);
        case (state_reg)
            S_IDLE:  x_op = reseed ? mag : seed_word;
            S_WARM:  x_op = {1'b0, x_out.res};
            default: x_op = x_reg;
        endcase
        if (state_reg == S_IDLE)
        begin
            y_op = {1'b0, gen2_reg};
        end
        else
        begin
            y_op = yop_reg;
        end
    end

    clss_modmul u_gen1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .coef   (clss_pkg::GEN1_COEF),
        .start  (x_start),
        .a      (x_op),
        .result (x_out)
    );

    clss_modmul u_gen2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .coef   (clss_pkg::GEN2_COEF),
        .start  (y_start),
        .a      (y_op),
        .result (y_out)
    );

    clss_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .start (y_start),
        .shuf  (shuf_reg),
        .done  (idx_done),
        .idx   (idx_res)
    );

    // table port control: fill during warm-up, replace on the regular step
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = x_reg[30:0];
        if ((state_reg == S_WARM) && x_out.done && (warm_reg < WARM_FILL))
        begin
            ram_we    = 1'b1;
            ram_waddr = warm_reg[AW-1:0];
            ram_wdata = x_out.res;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            ram_we = 1'b1;
        end
        ram_re = (state_reg == S_CALC) && x_out.done;
    end

    clss_ram #(
        .WIDTH (clss_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_res),
        .rdata (ram_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        yop_next       = yop_reg;
        gen2_next      = gen2_reg;
        shuf_next      = shuf_reg;
        warm_next      = warm_reg;
        idx_next       = idx_reg;
        rd_valid_next  = rd_valid_reg;
        diff_next      = diff_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !rand_ch.ready;
        seed_out_next  = seed_out_reg;
        raw_out_next   = raw_out_reg;

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (reseed)
                    begin
                        x_next     = mag;
                        yop_next   = mag;
                        warm_next  = WARM_FIRST;
                        state_next = S_WARM;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_WARM:
            begin
                if (x_out.done)
                begin
                    x_next = {1'b0, x_out.res};
                    if (warm_reg == '0)
                    begin
                        // last fill value is entry zero; it primes the shuffle
                        shuf_next  = x_out.res;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        warm_next = warm_reg - 1'b1;
                    end
                end
            end
            S_STEP:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (x_out.done)
                begin
                    x_next        = {1'b0, x_out.res};
                    gen2_next     = y_out.res;
                    idx_next      = idx_res;
                    rd_valid_next = valid_reg[idx_res];
                    state_next    = S_DIFF;
                end
            end
            S_DIFF:
            begin
                diff_next  = {1'b0, rd_data} - {1'b0, gen2_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    // wrap a difference below one into 1..MOD1-1
                    if (diff_reg[31] || (diff_reg == '0))
                    begin
                        shuf_next    = final_sum[30:0];
                        raw_out_next = final_sum[30:0];
                    end
                    else
                    begin
                        shuf_next    = diff_reg[30:0];
                        raw_out_next = diff_reg[30:0];
                    end
                    seed_out_next  = x_reg[30:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            yop_reg       <= '0;
            gen2_reg      <= clss_pkg::GEN2_INIT;
            shuf_reg      <= '0;
            warm_reg      <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            diff_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            seed_out_reg  <= '0;
            raw_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            yop_reg       <= yop_next;
            gen2_reg      <= gen2_next;
            shuf_reg      <= shuf_next;
            warm_reg      <= warm_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            diff_reg      <= diff_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            seed_out_reg  <= seed_out_next;
            raw_out_reg   <= raw_out_next;
        end
    end

    assign rand_ch.valid      = out_valid_reg;
    assign rand_ch.seed_out   = seed_out_reg;
    assign rand_ch.random_raw = raw_out_reg;

`ifndef SYNTH
    // second generator and index always finish together with the first
    assert property (@(posedge clk) disable iff (!rst_n)
        y_out.done |-> (x_out.done && idx_done))
        else $error("generator and index results out of step");

    // no back-to-back launches on the first generator
    assert property (@(posedge clk) disable iff (!rst_n)
        x_start |=> !x_start)
        else $error("first generator relaunched while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        idx_done |-> (32'(idx_res) < 32'(TABLE_DEPTH)))
        else $error("table index out of range");

    // wrapped shuffle value never reaches zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rand_ch.valid |-> (rand_ch.random_raw != '0))
        else $error("shuffled output is zero");
`endif

endmodule
